// ===== rtl/sb2da_pkg.sv =====
// Package for the signed binary to decimal ASCII converter.
// Holds the shared constants and the command and status structs.
// No dependencies.
package sb2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int RECIP_SH   = 35;
    localparam int QUOT_W     = PROD_W - RECIP_SH;

    localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam logic [VALUE_W-1:0] SIGN_BIT   = 32'h8000_0000;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [DIGIT_W-1:0] TEN        = 4'd10;

    typedef struct packed {
        logic load;
        logic step;
        logic pop;
        logic show_sign;
    } t_cmd;

    typedef struct packed {
        logic quot_zero;
        logic neg;
        logic last_digit;
    } t_sts;

endpackage

// ===== rtl/sb2da_dpath.sv =====
// Datapath of the converter: magnitude register, divide-by-ten step and digit stack.
// Depends on sb2da_pkg.
module sb2da_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sb2da_pkg::t_cmd               i_cmd,
    input  logic [sb2da_pkg::VALUE_W-1:0] i_value,
    output sb2da_pkg::t_sts               o_sts,
    output logic [sb2da_pkg::CHAR_W-1:0]  o_text_char
);
    import sb2da_pkg::*;

    logic [VALUE_W-1:0] r_mag;
    logic               r_neg;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIGIT_W-1:0] r_dig [MAX_DIGITS];

    logic [PROD_W-1:0]  prod;
    logic [QUOT_W-1:0]  quot;
    logic [DIGIT_W-1:0] quot_ten;
    logic [DIGIT_W-1:0] rem;

    // The remainder is below ten, so its low four bits are computed alone.
    assign prod     = {{VALUE_W{1'b0}}, r_mag} * {{VALUE_W{1'b0}}, RECIP_TEN};
    assign quot     = prod[PROD_W-1:RECIP_SH];
    assign quot_ten = {quot[DIGIT_W-4:0], 3'b000} + {quot[DIGIT_W-2:0], 1'b0};
    assign rem      = r_mag[DIGIT_W-1:0] - quot_ten;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[VALUE_W-1];
            r_mag <= i_value[VALUE_W-1] ? (~i_value + 1'b1) : i_value;
        end else if (i_cmd.step) begin
            r_mag <= VALUE_W'(quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_dig[0] <= rem;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_dig[i] <= r_dig[i-1];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
        end
    end

    assign o_sts.quot_zero  = (quot == '0);
    assign o_sts.neg        = r_neg;
    assign o_sts.last_digit = (r_cnt == CNT_W'(1));
    assign o_text_char      = i_cmd.show_sign ? CHAR_MINUS
                                              : (CHAR_ZERO + {4'b0000, r_dig[0]});

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DIGITS))
        else $error("digit count exceeds the stack depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_cnt != '0)
        else $error("pop from an empty digit stack");
    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_cnt == '0)
        else $error("digit count not cleared by load");
    a_step_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_cnt < CNT_W'(MAX_DIGITS))
        else $error("digit step with a full stack");
`endif

endmodule

// ===== rtl/sb2da_ctrl.sv =====
// Controller of the converter: sequences loading, digit steps and character output.
// Depends on sb2da_pkg.
module sb2da_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_last,
    input  sb2da_pkg::t_sts i_sts,
    output sb2da_pkg::t_cmd o_cmd
);
    import sb2da_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall, n_in_stall;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.quot_zero) begin
                    n_state = i_sts.neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                o_cmd.show_sign = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.last_digit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_stall  = (n_state != S_IDLE);
        n_out_valid = (n_state == S_SIGN) || (n_state == S_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= n_in_stall;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_last      = (r_state == S_EMIT) && i_sts.last_digit;

`ifndef SYNTHESIS
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGN) |-> !o_last)
        else $error("last flag set on the sign character");
    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (r_state != S_IDLE))
        else $error("input stall does not track the idle state");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after the last item");
`endif

endmodule

// ===== rtl/signed_binary_to_decimal_ascii.sv =====
// Top level of the signed 32-bit binary to decimal ASCII converter.
// Depends on sb2da_pkg, sb2da_ctrl and sb2da_dpath.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-----------------------
//  input   | i_in_valid   | o_in_stall   | i_value
//  output  | o_out_valid  | i_out_stall  | o_text_char, o_last
//
// A value with D decimal digits takes a load, D divide-by-ten steps and
// D output characters, plus one more for the sign when negative.
// Each digit cycle uses one reciprocal multiplier, so digits are computed one per cycle.
// Reset is synchronous and active low and returns the block to idle.
// Output stalls hold the current character; no new item is taken until the
// last character of the current one has been accepted.
module signed_binary_to_decimal_ascii (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sb2da_pkg::VALUE_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sb2da_pkg::CHAR_W-1:0]  o_text_char,
    output logic                          o_last
);
    import sb2da_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sb2da_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_last      (o_last),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sb2da_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .o_sts       (sts),
        .o_text_char (o_text_char)
    );

endmodule

// ===== tb/sv/sb2da_text_checker.sv =====
// Checker for the signed binary to decimal ASCII converter.
// Watches both channels, predicts the text of every accepted item and compares it.
// Depends on sb2da_pkg.
`timescale 1ns / 1ps
module sb2da_text_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [sb2da_pkg::VALUE_W-1:0] i_value,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [sb2da_pkg::CHAR_W-1:0]  i_text_char,
    input  logic                          i_last,
    output int                            o_fail_count,
    output int                            o_pending
);
    import sb2da_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last;
    } t_text_item;

    t_text_item expected_text[$];
    int         fail_total = 0;

    function automatic void push_decimal_text(logic [VALUE_W-1:0] word);
        logic [VALUE_W-1:0] mag;
        logic [DIGIT_W-1:0] digits[MAX_DIGITS];
        int                 ndig;
        mag  = word[VALUE_W-1] ? (~word + 1'b1) : word;
        ndig = 0;
        do begin
            digits[ndig] = DIGIT_W'(mag % 10);
            mag          = mag / 10;
            ndig++;
        end while (mag != 0 && ndig < MAX_DIGITS);
        if (word[VALUE_W-1]) begin
            expected_text.push_back('{text_char: CHAR_MINUS, last: 1'b0});
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            expected_text.push_back('{text_char: CHAR_ZERO + CHAR_W'(digits[k]),
                                      last: (k == 0)});
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_item want;
        if (!i_rst_n) begin
            expected_text.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                push_decimal_text(i_value);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_text.size() == 0) begin
                    $error("text_char mismatch: expected none, actual %h (last %b)",
                           i_text_char, i_last);
                    fail_total++;
                end else begin
                    want = expected_text.pop_front();
                    if (i_text_char !== want.text_char) begin
                        $error("text_char mismatch: expected %h, actual %h",
                               want.text_char, i_text_char);
                        fail_total++;
                    end
                    if (i_last !== want.last) begin
                        $error("last mismatch: expected %b, actual %b", want.last, i_last);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_text.size();
    end

endmodule

// ===== tb/sv/signed_binary_to_decimal_ascii_tb.sv =====
// Testbench top for the signed binary to decimal ASCII converter.
// Drives directed and random values with random idling on both sides.
// Depends on sb2da_pkg, signed_binary_to_decimal_ascii and sb2da_text_checker.
`timescale 1ns / 1ps
module signed_binary_to_decimal_ascii_tb;
    import sb2da_pkg::*;

    localparam int RANDOM_ITEMS  = 460;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 30;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic [VALUE_W-1:0] i_value     = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [CHAR_W-1:0]  o_text_char;
    logic               o_last;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    logic no_idle     = 1'b0;

    logic [VALUE_W-1:0] directed_values[] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
        32'd1234567890, -32'sd123456789, 32'd5, -32'sd5, 32'hEE6B_2800,
        -32'sd1000000000, 32'hAAAA_AAAA, 32'h5555_5555
    };

    signed_binary_to_decimal_ascii uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_text_char (o_text_char),
        .o_last      (o_last)
    );

    sb2da_text_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_text_char  (o_text_char),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned       ndig;
        longint unsigned   lo;
        longint unsigned   hi;
        longint unsigned   mag;
        logic              neg;
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        ndig = $urandom_range(1, 10);
        lo   = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi   = lo * 10 - 1;
        neg  = 1'($urandom_range(0, 1));
        if (ndig == 1) begin
            lo = 0;
        end
        if (hi > 64'd2147483647) begin
            hi = neg ? 64'd2147483648 : 64'd2147483647;
        end
        mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
        return neg ? VALUE_W'(-mag) : VALUE_W'(mag);
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_for_text();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_values[i]) begin
            send_value(directed_values[i]);
        end

        // The sender holds back until all text so far has been taken.
        i_in_valid <= 1'b0;
        wait_for_text();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            send_value(random_value());
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b0;

        wait_for_text();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        int hold;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = draw_wait();
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
